[rtl/cpu16ie_pkg.sv]
// ----------------------------------------------------------------------------
// cpu16ie_pkg: shared types and constants of the cpu16 instruction execute block
// Action and opcode codes, register file constants and the packed result word.
// ----------------------------------------------------------------------------
package cpu16ie_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned NUM_REGS  = 8;

  // Register number of the stack pointer.
  localparam logic [REG_IDX_W-1:0] SP_IDX = 3'd7;

  // Flag bit positions.
  localparam int unsigned FLAG_GT   = 0;
  localparam int unsigned FLAG_EQ   = 1;
  localparam int unsigned FLAG_LT   = 2;
  localparam int unsigned FLAG_HALT = 3;

  // What one input transaction asks for.
  typedef enum logic [1:0] {
    ACT_EXEC   = 2'd0,
    ACT_MEM_WR = 2'd1,
    ACT_MEM_RD = 2'd2,
    ACT_REG_RD = 2'd3
  } action_t;

  // Defined opcodes; codes above OP_NOP are reported as invalid.
  typedef enum logic [4:0] {
    OP_LLI  = 5'd0,
    OP_LUI  = 5'd1,
    OP_MOV  = 5'd2,
    OP_NOT  = 5'd3,
    OP_ADD  = 5'd4,
    OP_SUB  = 5'd5,
    OP_AND  = 5'd6,
    OP_OR   = 5'd7,
    OP_XOR  = 5'd8,
    OP_SHL  = 5'd9,
    OP_SHR  = 5'd10,
    OP_CMP  = 5'd11,
    OP_JMP  = 5'd12,
    OP_JEQ  = 5'd13,
    OP_JNE  = 5'd14,
    OP_JGT  = 5'd15,
    OP_JGE  = 5'd16,
    OP_JLT  = 5'd17,
    OP_JLE  = 5'd18,
    OP_PUSH = 5'd19,
    OP_POP  = 5'd20,
    OP_HLT  = 5'd21,
    OP_NOP  = 5'd22
  } opcode_t;

  // Result word, first field in the highest bits.
  typedef struct packed {
    logic [DATA_W-1:0] read_word;
    logic              halted;
    logic              less_flag;
    logic              equal_flag;
    logic              greater_flag;
    logic [DATA_W-1:0] pc_value;
    logic              status;
  } result_t;

  // Value of a register that has not been written since reset.
  function automatic logic [DATA_W-1:0] reg_reset_value(input logic [REG_IDX_W-1:0] idx);
    logic [DATA_W-1:0] val;
    val = (idx == SP_IDX) ? 16'hFFFF : 16'h0000;
    return val;
  endfunction

endpackage

[rtl/cpu16ie_ram.sv]
// ----------------------------------------------------------------------------
// cpu16ie_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value in cycles without a read.
// ----------------------------------------------------------------------------
module cpu16ie_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port; a read of the address being written returns old data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/cpu16_instruction_execute.sv]
// Path: a result passes through the execute stage and then the output register;
//   POP and MOV with a memory source also pass through the memory stage in between.
// Throughput: one transaction per cycle while the output accepts; POP and MOV with a
//   memory source, reading main memory before their final write, stall input in execute.
// Reset: registers read as 0 (stack pointer 0xFFFF), pc and flags clear at once; the
//   main memory is then zeroed word by word, and no input transaction is taken meanwhile.
// ----------------------------------------------------------------------------
// cpu16_instruction_execute: 16-bit instruction execute unit
// Executes one instruction or one host memory/register access per transaction,
// with the register file and the main memory held in synchronous RAMs.
// ----------------------------------------------------------------------------
module cpu16_instruction_execute #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // instruction[15:0], address[31:16], data[47:32],
                                  // reg_index[50:48], zero fill[55:51]
  input  logic [1:0]  in_tuser,   // action[1:0]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[0], pc_value[16:1], greater_flag[17],
                                  // equal_flag[18], less_flag[19], halted[20],
                                  // read_word[36:21], zero fill[39:37]
);

  localparam int unsigned MemDepth = 1 << ADDR_BITS;
  localparam int unsigned DW       = cpu16ie_pkg::DATA_W;
  localparam int unsigned RW       = cpu16ie_pkg::REG_IDX_W;

  // --------------------------------------------------------------------------
  // Input unpacking.
  // --------------------------------------------------------------------------
  logic                    in_accept;
  cpu16ie_pkg::action_t    in_action;
  logic [DW-1:0]           in_instr;
  logic [DW-1:0]           in_addr;
  logic [DW-1:0]           in_data;
  logic [RW-1:0]           in_ridx;
  logic [4:0]              in_op;

  assign in_accept = in_tvalid & in_tready;
  assign in_action = cpu16ie_pkg::action_t'(in_tuser);
  assign in_instr  = in_tdata[15:0];
  assign in_addr   = in_tdata[31:16];
  assign in_data   = in_tdata[47:32];
  assign in_ridx   = in_tdata[50:48];
  assign in_op     = in_instr[12:8];

  // --------------------------------------------------------------------------
  // Declarations.
  // --------------------------------------------------------------------------
  logic                  clr_busy_r;
  logic [ADDR_BITS-1:0]  clr_addr_r;

  logic [cpu16ie_pkg::NUM_REGS-1:0] reg_vld_r;
  logic [DW-1:0]         pc_r;
  logic [DW-1:0]         pc_nxt;
  logic [3:0]            flags_r;
  logic [3:0]            flags_nxt;

  // Register file ports (two copies share the write port).
  logic                  rf_we;
  logic [RW-1:0]         rf_waddr;
  logic [DW-1:0]         rf_wdata;
  logic [RW-1:0]         rf_xaddr;
  logic [RW-1:0]         rf_yaddr;
  logic [DW-1:0]         rf_xdata;
  logic [DW-1:0]         rf_ydata;

  // Main memory ports.
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_waddr;
  logic [DW-1:0]         mem_wdata;
  logic                  mem_re;
  logic [ADDR_BITS-1:0]  mem_raddr;
  logic [DW-1:0]         mem_rdata;
  logic                  mem_hit_r;
  logic [DW-1:0]         mem_fwd_r;
  logic [DW-1:0]         mem_rd_val;

  // Execute stage.
  logic                  e_valid_r;
  cpu16ie_pkg::action_t  e_action_r;
  logic [DW-1:0]         e_instr_r;
  logic [DW-1:0]         e_addr_r;
  logic [DW-1:0]         e_data_r;
  logic [RW-1:0]         e_xaddr_r;
  logic [RW-1:0]         e_yaddr_r;
  logic                  e_xhit_r;
  logic                  e_yhit_r;
  logic                  e_xvld_r;
  logic                  e_yvld_r;
  logic [DW-1:0]         e_fwd_r;

  logic [DW-1:0]         x_val;
  logic [DW-1:0]         y_val;
  logic [4:0]            e_op;
  logic [RW-1:0]         e_ra;
  logic [RW-1:0]         e_rb;
  logic                  e_go;
  logic                  e_needs_m;
  logic                  e_status;
  logic [DW-1:0]         e_rword;
  logic                  e_rf_we;
  logic [RW-1:0]         e_rf_waddr;
  logic [DW-1:0]         e_rf_wdata;
  logic                  e_mem_we;
  logic [ADDR_BITS-1:0]  e_mem_waddr;
  logic [DW-1:0]         e_mem_wdata;
  logic                  e_mem_re;
  logic [ADDR_BITS-1:0]  e_mem_raddr;
  logic                  e_m_tomem;
  logic [RW-1:0]         e_m_dst;
  logic                  jump_take;

  // Memory stage.
  logic                  m_valid_r;
  logic                  m_tomem_r;
  logic [RW-1:0]         m_dst_r;
  logic [ADDR_BITS-1:0]  m_maddr_r;
  logic                  m_fire;

  // Output register.
  logic                  out_valid_r;
  cpu16ie_pkg::result_t  out_res_r;
  logic                  can_push;

  // --------------------------------------------------------------------------
  // Flow control.
  // --------------------------------------------------------------------------
  assign can_push  = ~out_valid_r | out_tready;
  assign e_go      = e_valid_r & (e_needs_m | can_push);
  assign m_fire    = m_valid_r & can_push;
  assign in_tready = ~clr_busy_r & (~m_valid_r | m_fire) &
                     (~e_valid_r | (e_go & ~e_needs_m));

  // --------------------------------------------------------------------------
  // Register read address selection at accept.
  // --------------------------------------------------------------------------
  always_comb begin
    rf_xaddr = in_instr[6:4];
    rf_yaddr = in_instr[2:0];
    if (in_action == cpu16ie_pkg::ACT_REG_RD) begin
      rf_xaddr = in_ridx;
    end else begin
      if (in_op inside {cpu16ie_pkg::OP_LLI, cpu16ie_pkg::OP_LUI, cpu16ie_pkg::OP_CMP,
                        [cpu16ie_pkg::OP_JMP:cpu16ie_pkg::OP_JLE]}) begin
        rf_xaddr = in_instr[15:13];
      end
      if (in_op == cpu16ie_pkg::OP_PUSH || in_op == cpu16ie_pkg::OP_POP) begin
        rf_xaddr = cpu16ie_pkg::SP_IDX;
      end
      if (in_op == cpu16ie_pkg::OP_CMP) begin
        rf_yaddr = in_instr[6:4];
      end
      if (in_op == cpu16ie_pkg::OP_PUSH) begin
        rf_yaddr = in_instr[15:13];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Register file copies.
  // --------------------------------------------------------------------------
  cpu16ie_ram #(
    .WIDTH (DW),
    .DEPTH (cpu16ie_pkg::NUM_REGS)
  ) u_rf_x (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (in_accept),
    .raddr (rf_xaddr),
    .rdata (rf_xdata)
  );

  cpu16ie_ram #(
    .WIDTH (DW),
    .DEPTH (cpu16ie_pkg::NUM_REGS)
  ) u_rf_y (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (in_accept),
    .raddr (rf_yaddr),
    .rdata (rf_ydata)
  );

  // --------------------------------------------------------------------------
  // Main memory.
  // --------------------------------------------------------------------------
  cpu16ie_ram #(
    .WIDTH (DW),
    .DEPTH (MemDepth)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Host reads are issued at accept, instruction reads from the execute stage.
  always_comb begin
    mem_re    = e_go & e_mem_re;
    mem_raddr = e_mem_raddr;
    if (in_accept && in_action == cpu16ie_pkg::ACT_MEM_RD) begin
      mem_re    = 1'b1;
      mem_raddr = in_addr[ADDR_BITS-1:0];
    end
  end

  // Memory write port: clearing pass, memory stage or execute stage.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = e_mem_waddr;
    mem_wdata = e_mem_wdata;
    if (clr_busy_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (m_fire && m_tomem_r) begin
      mem_we    = 1'b1;
      mem_waddr = m_maddr_r;
      mem_wdata = mem_rd_val;
    end else if (e_go && e_mem_we) begin
      mem_we    = 1'b1;
    end
  end

  // Forward a write that lands in the same cycle as a memory read.
  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_hit_r <= mem_we & (mem_waddr == mem_raddr);
      mem_fwd_r <= mem_wdata;
    end
  end

  assign mem_rd_val = mem_hit_r ? mem_fwd_r : mem_rdata;

  // Clearing pass over the main memory after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Register write port and valid bits.
  // --------------------------------------------------------------------------
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = e_rf_waddr;
    rf_wdata = e_rf_wdata;
    if (m_fire && !m_tomem_r) begin
      rf_we    = 1'b1;
      rf_waddr = m_dst_r;
      rf_wdata = mem_rd_val;
    end else if (e_go && e_rf_we) begin
      rf_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_vld_r <= '0;
    end else if (rf_we) begin
      reg_vld_r[rf_waddr] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Execute stage registers; the forwarding flags cover a register write that
  // happens in the accept cycle.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (in_accept) begin
      e_valid_r <= 1'b1;
    end else if (e_go) begin
      e_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      e_action_r <= in_action;
      e_instr_r  <= in_instr;
      e_addr_r   <= in_addr;
      e_data_r   <= in_data;
      e_xaddr_r  <= rf_xaddr;
      e_yaddr_r  <= rf_yaddr;
      e_xhit_r   <= rf_we & (rf_waddr == rf_xaddr);
      e_yhit_r   <= rf_we & (rf_waddr == rf_yaddr);
      e_xvld_r   <= reg_vld_r[rf_xaddr];
      e_yvld_r   <= reg_vld_r[rf_yaddr];
      e_fwd_r    <= rf_wdata;
    end
  end

  // Operand values: forwarded write, stored value or reset value.
  always_comb begin
    if (e_xhit_r) begin
      x_val = e_fwd_r;
    end else if (e_xvld_r) begin
      x_val = rf_xdata;
    end else begin
      x_val = cpu16ie_pkg::reg_reset_value(e_xaddr_r);
    end
    if (e_yhit_r) begin
      y_val = e_fwd_r;
    end else if (e_yvld_r) begin
      y_val = rf_ydata;
    end else begin
      y_val = cpu16ie_pkg::reg_reset_value(e_yaddr_r);
    end
  end

  assign e_op = e_instr_r[12:8];
  assign e_ra = e_instr_r[15:13];
  assign e_rb = e_instr_r[6:4];

  // Jump condition from the current flags.
  always_comb begin
    case (e_op)
      cpu16ie_pkg::OP_JMP: jump_take = 1'b1;
      cpu16ie_pkg::OP_JEQ: jump_take = flags_r[cpu16ie_pkg::FLAG_EQ];
      cpu16ie_pkg::OP_JNE: jump_take = ~flags_r[cpu16ie_pkg::FLAG_EQ];
      cpu16ie_pkg::OP_JGT: jump_take = flags_r[cpu16ie_pkg::FLAG_GT];
      cpu16ie_pkg::OP_JGE: jump_take = ~flags_r[cpu16ie_pkg::FLAG_LT];
      cpu16ie_pkg::OP_JLT: jump_take = flags_r[cpu16ie_pkg::FLAG_LT];
      cpu16ie_pkg::OP_JLE: jump_take = ~flags_r[cpu16ie_pkg::FLAG_GT];
      default:             jump_take = 1'b0;
    endcase
  end

  // Execute stage datapath.
  always_comb begin
    e_needs_m   = 1'b0;
    e_status    = 1'b0;
    e_rword     = '0;
    e_rf_we     = 1'b0;
    e_rf_waddr  = e_ra;
    e_rf_wdata  = '0;
    e_mem_we    = 1'b0;
    e_mem_waddr = x_val[ADDR_BITS-1:0];
    e_mem_wdata = y_val;
    e_mem_re    = 1'b0;
    e_mem_raddr = y_val[ADDR_BITS-1:0];
    e_m_tomem   = 1'b0;
    e_m_dst     = e_rb;
    pc_nxt      = pc_r;
    flags_nxt   = flags_r;
    case (e_action_r)
      cpu16ie_pkg::ACT_EXEC: begin
        if (e_op > cpu16ie_pkg::OP_NOP) begin
          e_status = 1'b1;
        end else begin
          case (e_op)
            cpu16ie_pkg::OP_LLI: begin
              e_rf_we    = 1'b1;
              e_rf_wdata = {x_val[15:8], e_instr_r[7:0]};
            end
            cpu16ie_pkg::OP_LUI: begin
              e_rf_we    = 1'b1;
              e_rf_wdata = {e_instr_r[7:0], x_val[7:0]};
            end
            cpu16ie_pkg::OP_MOV: begin
              if (e_instr_r[3]) begin
                // Memory source: read now, finish in the memory stage.
                e_needs_m = 1'b1;
                e_mem_re  = 1'b1;
                e_m_tomem = e_instr_r[7];
              end else if (e_instr_r[7]) begin
                e_mem_we = 1'b1;
              end else begin
                e_rf_we    = 1'b1;
                e_rf_waddr = e_rb;
                e_rf_wdata = y_val;
              end
            end
            cpu16ie_pkg::OP_NOT: begin
              e_rf_we    = 1'b1;
              e_rf_wdata = ~x_val;
            end
            cpu16ie_pkg::OP_ADD: begin
              e_rf_we    = 1'b1;
              e_rf_wdata = x_val + y_val;
            end
            cpu16ie_pkg::OP_SUB: begin
              e_rf_we    = 1'b1;
              e_rf_wdata = x_val - y_val;
            end
            cpu16ie_pkg::OP_AND: begin
              e_rf_we    = 1'b1;
              e_rf_wdata = x_val & y_val;
            end
            cpu16ie_pkg::OP_OR: begin
              e_rf_we    = 1'b1;
              e_rf_wdata = x_val | y_val;
            end
            cpu16ie_pkg::OP_XOR: begin
              e_rf_we    = 1'b1;
              e_rf_wdata = x_val ^ y_val;
            end
            cpu16ie_pkg::OP_SHL: begin
              e_rf_we    = 1'b1;
              e_rf_wdata = x_val << e_instr_r[3:0];
            end
            cpu16ie_pkg::OP_SHR: begin
              e_rf_we    = 1'b1;
              e_rf_wdata = x_val >> e_instr_r[3:0];
            end
            cpu16ie_pkg::OP_CMP: begin
              flags_nxt[cpu16ie_pkg::FLAG_GT] = (x_val > y_val);
              flags_nxt[cpu16ie_pkg::FLAG_EQ] = (x_val == y_val);
              flags_nxt[cpu16ie_pkg::FLAG_LT] = (x_val < y_val);
            end
            cpu16ie_pkg::OP_PUSH: begin
              // Store A at the stack pointer, then move the pointer down.
              e_mem_we   = 1'b1;
              e_rf_we    = 1'b1;
              e_rf_waddr = cpu16ie_pkg::SP_IDX;
              e_rf_wdata = x_val - 16'd1;
            end
            cpu16ie_pkg::OP_POP: begin
              // Move the pointer up, read there, load A in the memory stage.
              e_rf_we     = 1'b1;
              e_rf_waddr  = cpu16ie_pkg::SP_IDX;
              e_rf_wdata  = x_val + 16'd1;
              e_needs_m   = 1'b1;
              e_mem_re    = 1'b1;
              e_mem_raddr = e_rf_wdata[ADDR_BITS-1:0];
              e_m_dst     = e_ra;
            end
            cpu16ie_pkg::OP_HLT: begin
              flags_nxt[cpu16ie_pkg::FLAG_HALT] = 1'b1;
            end
            default: begin
              // Jumps load the target minus one; the no-op does nothing.
              if (jump_take) begin
                pc_nxt = x_val - 16'd1;
              end
            end
          endcase
        end
      end
      cpu16ie_pkg::ACT_MEM_WR: begin
        e_mem_we    = 1'b1;
        e_mem_waddr = e_addr_r[ADDR_BITS-1:0];
        e_mem_wdata = e_data_r;
      end
      cpu16ie_pkg::ACT_MEM_RD: begin
        e_rword = mem_rd_val;
      end
      default: begin
        e_rword = x_val;
      end
    endcase
  end

  // Program counter and flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= '0;
      flags_r <= '0;
    end else if (e_go) begin
      pc_r    <= pc_nxt;
      flags_r <= flags_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Memory stage for POP and MOV with a memory source.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (e_go && e_needs_m) begin
      m_valid_r <= 1'b1;
    end else if (m_fire) begin
      m_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_go && e_needs_m) begin
      m_tomem_r <= e_m_tomem;
      m_dst_r   <= e_m_dst;
      m_maddr_r <= x_val[ADDR_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (m_fire || (e_go && !e_needs_m)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_fire) begin
      out_res_r.status       <= 1'b0;
      out_res_r.pc_value     <= pc_r;
      out_res_r.greater_flag <= flags_r[cpu16ie_pkg::FLAG_GT];
      out_res_r.equal_flag   <= flags_r[cpu16ie_pkg::FLAG_EQ];
      out_res_r.less_flag    <= flags_r[cpu16ie_pkg::FLAG_LT];
      out_res_r.halted       <= flags_r[cpu16ie_pkg::FLAG_HALT];
      out_res_r.read_word    <= '0;
    end else if (e_go && !e_needs_m) begin
      out_res_r.status       <= e_status;
      out_res_r.pc_value     <= pc_nxt;
      out_res_r.greater_flag <= flags_nxt[cpu16ie_pkg::FLAG_GT];
      out_res_r.equal_flag   <= flags_nxt[cpu16ie_pkg::FLAG_EQ];
      out_res_r.less_flag    <= flags_nxt[cpu16ie_pkg::FLAG_LT];
      out_res_r.halted       <= flags_nxt[cpu16ie_pkg::FLAG_HALT];
      out_res_r.read_word    <= e_rword;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // The execute and memory stages never hold transactions at the same time.
  a_stage_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(e_valid_r && m_valid_r))
    else $error("execute and memory stages both occupied");

  // A transaction that needs the memory stage moves there in the next cycle.
  a_m_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (e_valid_r && e_needs_m) |=> (m_valid_r && !e_valid_r))
    else $error("memory stage handoff lost");

  // No register write and no occupied stage during the clearing pass.
  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!rf_we && !e_valid_r && !m_valid_r))
    else $error("activity during memory clearing pass");

  // The memory stage leaves pc and flags alone.
  a_m_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    m_valid_r |=> (pc_r == $past(pc_r) && flags_r == $past(flags_r)))
    else $error("pc or flags changed by memory stage");

endmodule
